@@ rtl/rrlh_pkg.sv @@
package rrlh_pkg;

   // Thread id width carried on the ports and held in the slot table.
   localparam int ID_WIDTH = 10;

   // Stream data widths, padded to whole bytes.
   localparam int REQ_DATA_WIDTH = 16;
   localparam int RSP_DATA_WIDTH = 16;
   localparam int REQ_USED_WIDTH = 2 + ID_WIDTH;
   localparam int RSP_USED_WIDTH = 3 + 1 + ID_WIDTH;

   // Request codes.
   typedef enum logic [1:0] {
      FUNC_LOCK   = 2'd0,
      FUNC_TRY    = 2'd1,
      FUNC_UNLOCK = 2'd2
   } func_type;

   // Result codes.
   typedef enum logic [2:0] {
      ST_GRANTED  = 3'd0,
      ST_QUEUED   = 3'd1,
      ST_FULL     = 3'd2,
      ST_IGNORED  = 3'd3,
      ST_RELEASED = 3'd4
   } status_type;

   // Commands from the sequencer to the scan unit.
   typedef struct packed {
      logic load;
      logic step;
      logic down;
   } scan_ctrl_type;

   // Flags from the scan unit back to the sequencer.
   typedef struct packed {
      logic hit;
      logic wait_hit;
      logic exhausted;
   } scan_flags_type;

endpackage

@@ rtl/round_robin_lock_handoff.sv @@
// Round-robin lock arbiter with a table of registered threads.
//
// The req_ channel carries one item per request: a lock, a try-lock or an
// unlock, together with the thread id. The rsp_ channel returns exactly one
// item per request: a status code, whether the lock has an owner, and the
// owner's thread id (zero when free). A thread takes the next free slot on
// its first lock or try-lock. An unlock from the owner hands the lock to the
// next waiting slot in descending slot order, wrapping to the newest slot.
//
// Items are taken one at a time. A lock or try-lock is settled by the lookup,
// which compares one slot per cycle through the single read port of the slot
// table. An unlock is settled by the scan of waiting flags, one slot per cycle,
// and on a handoff by a read of the new owner's id from the table. The next
// item is taken in the cycle after the result is written.
//
// Reset clears the table, the waiting flags and the owner at once; the ids in
// the table need no clearing since only registered slots are read. The result
// sits in an output register; a new item is accepted while it waits, but the
// next result is held until the receiver takes the previous one.
module round_robin_lock_handoff
   import rrlh_pkg::*;
#(
   parameter int MAX_THREADS = 16
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  logic [REQ_DATA_WIDTH-1:0] req_tdata,   // func[1:0], thread_id[11:2]
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   output logic [RSP_DATA_WIDTH-1:0] rsp_tdata    // status[2:0], owner_valid[3],
                                                  // owner_thread[13:4]
);

   localparam int IW = $clog2(MAX_THREADS);
   localparam int CW = $clog2(MAX_THREADS + 1);

   typedef enum logic [2:0] {
      S_IDLE,
      S_LOOKUP,
      S_HAND,
      S_FETCH,
      S_DONE
   } state_type;

   state_type            state_ff, state_in;
   func_type             func_ff, func_in;
   logic [ID_WIDTH-1:0]  key_ff, key_in;
   status_type           status_ff, status_in;
   logic [CW-1:0]        slots_used_ff, slots_used_in;
   logic [MAX_THREADS-1:0] waiting_ff, waiting_in;
   logic                 has_owner_ff, has_owner_in;
   logic [IW-1:0]        owner_slot_ff, owner_slot_in;
   logic [ID_WIDTH-1:0]  owner_id_ff, owner_id_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_WIDTH-1:0] rsp_data_ff, rsp_data_in;

   logic                 req_accept;
   func_type             req_func;
   logic [ID_WIDTH-1:0]  req_id;
   logic                 out_free;
   logic                 table_full;
   logic                 grant_en;
   logic [IW-1:0]        grant_slot;
   logic [ID_WIDTH-1:0]  owner_thread;

   scan_ctrl_type        scan_ctrl;
   scan_flags_type       scan_flags;
   logic [IW-1:0]        scan_start;
   logic [IW-1:0]        scan_hit_idx;
   logic [IW-1:0]        ram_rd_addr;
   logic [ID_WIDTH-1:0]  ram_rd_data;
   logic                 ram_wr_en;

   assign req_accept = req_tvalid && req_tready;
   assign req_func   = func_type'(req_tdata[1:0]);
   assign req_id     = req_tdata[REQ_USED_WIDTH-1:2];
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign table_full = (slots_used_ff == CW'(MAX_THREADS));
   assign scan_start = owner_slot_ff;

   // Slot table of registered thread ids.
   rrlh_ram #(
      .WIDTH (ID_WIDTH),
      .DEPTH (MAX_THREADS)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (slots_used_ff[IW-1:0]),
      .wr_data (key_ff),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // Shared scan unit for id lookup and waiting-flag search.
   rrlh_scan #(
      .MAX_THREADS (MAX_THREADS)
   ) u_scan (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (scan_ctrl),
      .start_idx (scan_start),
      .used      (slots_used_ff),
      .key       (key_ff),
      .rd_data   (ram_rd_data),
      .waiting   (waiting_ff),
      .rd_addr   (ram_rd_addr),
      .hit_idx   (scan_hit_idx),
      .flags     (scan_flags)
   );

   // Sequencer.
   always_comb begin
      state_in      = state_ff;
      func_in       = func_ff;
      key_in        = key_ff;
      status_in     = status_ff;
      slots_used_in = slots_used_ff;
      waiting_in    = waiting_ff;
      has_owner_in  = has_owner_ff;
      owner_slot_in = owner_slot_ff;
      owner_id_in   = owner_id_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_data_in   = rsp_data_ff;
      scan_ctrl     = '0;
      ram_wr_en     = 1'b0;
      grant_en      = 1'b0;
      grant_slot    = scan_hit_idx;

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               func_in = req_func;
               key_in  = req_id;
               unique case (req_func) inside
                  FUNC_LOCK, FUNC_TRY: begin
                     scan_ctrl.load = 1'b1;
                     state_in       = S_LOOKUP;
                  end
                  FUNC_UNLOCK: begin
                     if (has_owner_ff && (req_id == owner_id_ff)) begin
                        waiting_in[owner_slot_ff] = 1'b0;
                        scan_ctrl.load = 1'b1;
                        scan_ctrl.down = 1'b1;
                        state_in       = S_HAND;
                     end else begin
                        status_in = ST_IGNORED;
                        state_in  = S_DONE;
                     end
                  end
                  default: begin
                     status_in = ST_IGNORED;
                     state_in  = S_DONE;
                  end
               endcase
            end
         end
         S_LOOKUP: begin
            scan_ctrl.step = 1'b1;
            if (scan_flags.hit) begin
               grant_en = 1'b1;
               if (func_ff == FUNC_LOCK) begin
                  waiting_in[scan_hit_idx] = 1'b1;
               end
               state_in = S_DONE;
            end else if (scan_flags.exhausted) begin
               if (table_full) begin
                  status_in = ST_FULL;
               end else begin
                  // Register the thread in the next free slot.
                  ram_wr_en  = 1'b1;
                  grant_en   = 1'b1;
                  grant_slot = slots_used_ff[IW-1:0];
                  waiting_in[slots_used_ff[IW-1:0]] = (func_ff == FUNC_LOCK);
                  slots_used_in = CW'(slots_used_ff + 1'b1);
               end
               state_in = S_DONE;
            end
         end
         S_HAND: begin
            scan_ctrl.step = 1'b1;
            scan_ctrl.down = 1'b1;
            status_in      = ST_RELEASED;
            if (scan_flags.wait_hit) begin
               // The table read of the new owner's slot is under way.
               owner_slot_in = scan_hit_idx;
               state_in      = S_FETCH;
            end else if (scan_flags.exhausted) begin
               has_owner_in  = 1'b0;
               owner_slot_in = '0;
               owner_id_in   = '0;
               state_in      = S_DONE;
            end
         end
         S_FETCH: begin
            owner_id_in = ram_rd_data;
            state_in    = S_DONE;
         end
         S_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = RSP_DATA_WIDTH'({owner_thread, has_owner_ff, status_ff});
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // Grant when the lock is free or already held by this slot; else report queued.
      if (grant_en) begin
         if (has_owner_ff) begin
            status_in = (owner_slot_ff == grant_slot) ? ST_GRANTED : ST_QUEUED;
         end else begin
            has_owner_in  = 1'b1;
            owner_slot_in = grant_slot;
            owner_id_in   = key_ff;
            status_in     = ST_GRANTED;
         end
      end
   end

   assign owner_thread = has_owner_ff ? owner_id_ff : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         slots_used_ff <= '0;
         waiting_ff    <= '0;
         has_owner_ff  <= 1'b0;
         owner_slot_ff <= '0;
         owner_id_ff   <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         slots_used_ff <= slots_used_in;
         waiting_ff    <= waiting_in;
         has_owner_ff  <= has_owner_in;
         owner_slot_ff <= owner_slot_in;
         owner_id_ff   <= owner_id_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      func_ff     <= func_in;
      key_ff      <= key_in;
      status_ff   <= status_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // The owner always sits in a registered slot.
   assert property (@(posedge clock) disable iff (reset)
      has_owner_ff |-> (CW'(owner_slot_ff) < slots_used_ff))
      else $error("owner slot beyond registered slots");

   // A free lock reports no owner id.
   assert property (@(posedge clock) disable iff (reset)
      !has_owner_ff |-> (owner_id_ff == '0))
      else $error("owner id held while lock is free");

   // The table never grows past its depth.
   assert property (@(posedge clock) disable iff (reset)
      slots_used_ff <= CW'(MAX_THREADS))
      else $error("slot count overflow");

   // No new item is taken in the cycle after one is accepted.
   assert property (@(posedge clock) disable iff (reset)
      req_accept |=> !req_tready)
      else $error("new item taken while one is in work");

endmodule

@@ rtl/rrlh_ram.sv @@
module rrlh_ram #(
   parameter int WIDTH = 10,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // One write port and one registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/rrlh_scan.sv @@
module rrlh_scan
   import rrlh_pkg::*;
#(
   parameter int MAX_THREADS = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   input  scan_ctrl_type                      ctrl,
   input  logic [$clog2(MAX_THREADS)-1:0]     start_idx,
   input  logic [$clog2(MAX_THREADS+1)-1:0]   used,
   input  logic [ID_WIDTH-1:0]                key,
   input  logic [ID_WIDTH-1:0]                rd_data,
   input  logic [MAX_THREADS-1:0]             waiting,
   output logic [$clog2(MAX_THREADS)-1:0]     rd_addr,
   output logic [$clog2(MAX_THREADS)-1:0]     hit_idx,
   output scan_flags_type                     flags
);

   localparam int IW = $clog2(MAX_THREADS);
   localparam int CW = $clog2(MAX_THREADS + 1);

   logic [IW-1:0] idx_ff, idx_in;
   logic [CW-1:0] left_ff, left_in;
   logic          pend_ff, pend_in;
   logic [IW-1:0] pend_idx_ff, pend_idx_in;
   logic [CW-1:0] used_m1;
   logic [IW-1:0] idx_down;
   logic [IW-1:0] start_down;

   // Descending slot order wraps from slot 0 to the newest slot.
   assign used_m1    = used - 1'b1;
   assign idx_down   = (idx_ff == '0) ? used_m1[IW-1:0] : IW'(idx_ff - 1'b1);
   assign start_down = (start_idx == '0) ? used_m1[IW-1:0] : IW'(start_idx - 1'b1);

   // One slot per cycle: an id compare going up, a waiting check going down.
   always_comb begin
      idx_in      = idx_ff;
      left_in     = left_ff;
      pend_in     = 1'b0;
      pend_idx_in = pend_idx_ff;
      if (ctrl.load) begin
         if (ctrl.down) begin
            idx_in  = start_down;
            left_in = used_m1;
         end else begin
            idx_in  = '0;
            left_in = used;
         end
      end else if (ctrl.step && (left_ff != '0)) begin
         if (ctrl.down) begin
            if (!waiting[idx_ff]) begin
               idx_in  = idx_down;
               left_in = CW'(left_ff - 1'b1);
            end
         end else begin
            pend_in     = 1'b1;
            pend_idx_in = idx_ff;
            idx_in      = IW'(idx_ff + 1'b1);
            left_in     = CW'(left_ff - 1'b1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff      <= '0;
         left_ff     <= '0;
         pend_ff     <= 1'b0;
         pend_idx_ff <= '0;
      end else begin
         idx_ff      <= idx_in;
         left_ff     <= left_in;
         pend_ff     <= pend_in;
         pend_idx_ff <= pend_idx_in;
      end
   end

   // The read data of the slot issued last cycle is compared now.
   assign rd_addr         = idx_ff;
   assign hit_idx         = ctrl.down ? idx_ff : pend_idx_ff;
   assign flags.hit       = pend_ff && (rd_data == key);
   assign flags.wait_hit  = (left_ff != '0) && waiting[idx_ff];
   assign flags.exhausted = (left_ff == '0) && !pend_ff;

endmodule

@@ verif/tb_round_robin_lock_handoff.sv @@
`timescale 1ns / 1ps

module tb_round_robin_lock_handoff;
   import rrlh_pkg::*;

   localparam int TABLE_DEPTH = 16;
   localparam int RANDOM_ITEMS = 1200;
   localparam int PHASE_ITEMS = RANDOM_ITEMS / 3;
   localparam int HOLDOFF_AT = 950;
   localparam int HOLDOFF_CYCLES = 300;
   localparam int STALL_LIMIT = 2000;
   localparam int DRAIN_CYCLES = 40;
   localparam int MAX_REPORTS = 10;

   // Request code that the block does not define; it must be ignored.
   localparam logic [1:0] FUNC_UNDEFINED = 2'd3;

   // One response item, field by field.
   typedef struct packed {
      status_type          status;
      logic                owner_valid;
      logic [ID_WIDTH-1:0] owner_thread;
   } lock_reply_type;

   // One row of the directed stimulus table.
   typedef struct {
      logic [1:0]          func;
      logic [ID_WIDTH-1:0] thread_id;
      bit                  typed;
      lock_reply_type      reply;
   } request_row_type;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_tvalid = 1'b0;
   logic                      req_tready;
   logic [REQ_DATA_WIDTH-1:0] req_tdata = '0;   // func[1:0], thread_id[11:2]
   logic                      rsp_tvalid;
   logic                      rsp_tready = 1'b0;
   logic [RSP_DATA_WIDTH-1:0] rsp_tdata;        // status[2:0], owner_valid[3],
                                                // owner_thread[13:4]

   // Shadow copy of the arbiter's table and lock owner.
   logic [ID_WIDTH-1:0] tbl_thread [TABLE_DEPTH];
   bit                  tbl_waiting [TABLE_DEPTH];
   int                  tbl_count;
   bit                  lock_held;
   int                  holder_slot;

   lock_reply_type  replies_due[$];
   request_row_type directed_rows[$];

   int items_accepted = 0;
   int replies_checked = 0;
   int mismatch_count = 0;
   int status_seen [8];
   int req_idle_pct = 0;
   int rsp_idle_pct = 0;
   bit holdoff_done = 1'b0;

   round_robin_lock_handoff uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #5 clock = ~clock;

   // Works out the reply to one request and advances the shadow state.
   function automatic lock_reply_type predict_lock_reply(input logic [1:0] func,
                                                         input logic [ID_WIDTH-1:0] id);
      lock_reply_type r;
      int             slot;
      int             idx;
      bit             handed;
      slot = TABLE_DEPTH;
      handed = 1'b0;
      r.status = ST_IGNORED;
      if (func == FUNC_LOCK || func == FUNC_TRY) begin
         for (int i = 0; i < tbl_count; i++) begin
            if (tbl_thread[i] == id && slot == TABLE_DEPTH) slot = i;
         end
         // A new thread takes the next free slot if there is one.
         if (slot == TABLE_DEPTH && tbl_count < TABLE_DEPTH) begin
            slot = tbl_count;
            tbl_thread[slot] = id;
            tbl_waiting[slot] = 1'b0;
            tbl_count++;
         end
         if (slot == TABLE_DEPTH) begin
            r.status = ST_FULL;
         end else begin
            if (func == FUNC_LOCK) tbl_waiting[slot] = 1'b1;
            if (!lock_held) begin
               lock_held = 1'b1;
               holder_slot = slot;
               r.status = ST_GRANTED;
            end else if (holder_slot == slot) begin
               r.status = ST_GRANTED;
            end else begin
               r.status = ST_QUEUED;
            end
         end
      end else if (func == FUNC_UNLOCK) begin
         if (lock_held && tbl_thread[holder_slot] == id) begin
            // Hand over to the next waiting slot, counting down and wrapping.
            tbl_waiting[holder_slot] = 1'b0;
            for (int k = 1; k < tbl_count && !handed; k++) begin
               idx = (holder_slot + tbl_count - k) % tbl_count;
               if (tbl_waiting[idx]) begin
                  holder_slot = idx;
                  handed = 1'b1;
               end
            end
            if (!handed) begin
               lock_held = 1'b0;
               holder_slot = 0;
            end
            r.status = ST_RELEASED;
         end
      end
      r.owner_valid = lock_held;
      r.owner_thread = lock_held ? tbl_thread[holder_slot] : '0;
      return r;
   endfunction

   // Picks the id of a thread that already holds a slot.
   function automatic logic [ID_WIDTH-1:0] registered_thread();
      return tbl_thread[$urandom_range(0, tbl_count - 1)];
   endfunction

   task automatic add_row(input logic [1:0] func, input logic [ID_WIDTH-1:0] id,
                          input bit typed, input status_type st, input logic ov,
                          input logic [ID_WIDTH-1:0] ot);
      request_row_type row;
      row.func = func;
      row.thread_id = id;
      row.typed = typed;
      row.reply = '{st, ov, ot};
      directed_rows.push_back(row);
   endtask

   // Offers one request item and records its reply once it is accepted.
   task automatic send_request(input logic [1:0] func, input logic [ID_WIDTH-1:0] id,
                               input bit typed, input lock_reply_type typed_reply);
      lock_reply_type predicted;
      while ($urandom_range(0, 99) < req_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {{(REQ_DATA_WIDTH - REQ_USED_WIDTH){1'b0}}, id, func};
      do @(posedge clock); while (!req_tready);
      items_accepted++;
      predicted = predict_lock_reply(func, id);
      replies_due.push_back(typed ? typed_reply : predicted);
   endtask

   task automatic note_mismatch(input string what, input lock_reply_type want,
                                input logic [RSP_DATA_WIDTH-1:0] got);
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS)
         $display({"mismatch at %0t (%s): expected status %0d valid %0b owner %0d,",
                   " got status %0d valid %0b owner %0d"},
                  $realtime, what, want.status, want.owner_valid, want.owner_thread,
                  got[2:0], got[3], got[13:4]);
   endtask

   // Receiver: random back-pressure plus one long hold-off once traffic is flowing.
   initial begin : receiver
      forever begin
         @(posedge clock);
         if (!holdoff_done && items_accepted >= HOLDOFF_AT) begin
            holdoff_done = 1'b1;
            rsp_tready <= 1'b0;
            repeat (HOLDOFF_CYCLES) @(posedge clock);
         end else begin
            rsp_tready <= ($urandom_range(0, 99) >= rsp_idle_pct);
         end
      end
   end

   // Each accepted reply is checked against the oldest one due.
   always @(posedge clock) begin : reply_check
      lock_reply_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         status_seen[rsp_tdata[2:0]]++;
         if (replies_due.size() == 0) begin
            note_mismatch("no reply was due", '0, rsp_tdata);
         end else begin
            want = replies_due.pop_front();
            replies_checked++;
            if (rsp_tdata[2:0] !== want.status)
               note_mismatch("status", want, rsp_tdata);
            else if (rsp_tdata[3] !== want.owner_valid)
               note_mismatch("owner_valid", want, rsp_tdata);
            else if (rsp_tdata[13:4] !== want.owner_thread)
               note_mismatch("owner_thread", want, rsp_tdata);
         end
      end
   end

   // Watchdog: ends the run when no item moves on either channel for too long.
   initial begin : watchdog
      int stall_cycles;
      stall_cycles = 0;
      while (stall_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
            stall_cycles = 0;
         else
            stall_cycles++;
      end
      $display("timeout: no item moved for %0d cycles, %0d replies still due",
               STALL_LIMIT, replies_due.size());
      $display("FAIL");
      $finish;
   end

   initial begin : stimulus
      logic [1:0]          func;
      logic [ID_WIDTH-1:0] id;
      int                  pick;
      tbl_count = 0;
      lock_held = 1'b0;
      holder_slot = 0;
      foreach (tbl_waiting[i]) begin
         tbl_waiting[i] = 1'b0;
         tbl_thread[i] = '0;
      end

      // Directed table: idle arbiter, repeated lock, handoff, full table, wrap.
      add_row(FUNC_UNLOCK, 10'd0, 1'b1, ST_IGNORED, 1'b0, 10'd0);
      add_row(FUNC_UNDEFINED, 10'd1023, 1'b1, ST_IGNORED, 1'b0, 10'd0);
      add_row(FUNC_LOCK, 10'd0, 1'b1, ST_GRANTED, 1'b1, 10'd0);
      add_row(FUNC_LOCK, 10'd0, 1'b1, ST_GRANTED, 1'b1, 10'd0);
      add_row(FUNC_TRY, 10'd1023, 1'b1, ST_QUEUED, 1'b1, 10'd0);
      add_row(FUNC_LOCK, 10'd1023, 1'b0, ST_GRANTED, 1'b0, 10'd0);
      add_row(FUNC_UNLOCK, 10'd1023, 1'b1, ST_IGNORED, 1'b1, 10'd0);
      add_row(FUNC_UNLOCK, 10'd0, 1'b0, ST_GRANTED, 1'b0, 10'd0);
      add_row(FUNC_TRY, 10'd0, 1'b0, ST_GRANTED, 1'b0, 10'd0);
      add_row(FUNC_UNLOCK, 10'd1023, 1'b1, ST_RELEASED, 1'b0, 10'd0);
      add_row(FUNC_TRY, 10'h155, 1'b0, ST_GRANTED, 1'b0, 10'd0);
      add_row(FUNC_LOCK, 10'h2AA, 1'b0, ST_GRANTED, 1'b0, 10'd0);
      // The remaining slots fill with waiting threads.
      for (int k = 1; k <= 12; k++)
         add_row(FUNC_LOCK, 10'(16 * k + 3), 1'b0, ST_GRANTED, 1'b0, 10'd0);
      add_row(FUNC_LOCK, 10'd512, 1'b1, ST_FULL, 1'b1, 10'h155);
      add_row(FUNC_TRY, 10'd513, 1'b1, ST_FULL, 1'b1, 10'h155);
      // Owner in slot 2 gives up; the search wraps past slot 0 to the newest slot.
      add_row(FUNC_UNLOCK, 10'h155, 1'b0, ST_GRANTED, 1'b0, 10'd0);

      req_idle_pct = 36;
      rsp_idle_pct = 72;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i])
         send_request(directed_rows[i].func, directed_rows[i].thread_id,
                      directed_rows[i].typed, directed_rows[i].reply);

      // Random traffic: mostly well-formed lock, try and owner unlock sequences.
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n == PHASE_ITEMS) begin
            req_idle_pct = 72;
            rsp_idle_pct = 36;
         end else if (n == 2 * PHASE_ITEMS) begin
            req_idle_pct = 0;
            rsp_idle_pct = 0;
         end
         pick = $urandom_range(0, 99);
         if (pick < 40 && lock_held) begin
            func = FUNC_UNLOCK;
            id = tbl_thread[holder_slot];
         end else if (pick < 70) begin
            func = FUNC_LOCK;
            id = registered_thread();
         end else if (pick < 85) begin
            func = FUNC_TRY;
            id = registered_thread();
         end else if (pick < 90) begin
            func = FUNC_UNLOCK;
            id = registered_thread();
         end else if (pick < 95) begin
            func = $urandom_range(0, 1) ? FUNC_LOCK : FUNC_TRY;
            id = ID_WIDTH'($urandom_range(0, 1023));
         end else begin
            func = $urandom_range(0, 1) ? FUNC_UNDEFINED : FUNC_UNLOCK;
            id = ID_WIDTH'($urandom_range(0, 1023));
         end
         send_request(func, id, 1'b0, '0);
      end
      req_tvalid <= 1'b0;

      while (replies_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Run covered %0d requests (%0d directed) and %0d checked replies, %0d mismatches.",
               items_accepted, directed_rows.size(), replies_checked, mismatch_count);
      $display("Replies: %0d granted, %0d queued, %0d full, %0d ignored, %0d released.",
               status_seen[ST_GRANTED], status_seen[ST_QUEUED], status_seen[ST_FULL],
               status_seen[ST_IGNORED], status_seen[ST_RELEASED]);
      if (mismatch_count == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule
